FILE: rtl/core/hcbd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hcbd_pkg
// shared types and constants of the chunked body decoder
// ----------------------------------------------------------------------------
package hcbd_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_BODY_MODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTENT_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LIMIT     = 2'd2;

  localparam logic [1:0] MODE_CHUNKED = 2'd0;
  localparam logic [1:0] MODE_FIXED   = 2'd1;

  localparam logic [62:0] SIZE_LIMIT_RST = 63'd16777216;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_BAD_SIZE = 3'd1,
    ERR_BAD_TERM = 3'd2,
    ERR_LONG     = 3'd3,
    ERR_LIMIT    = 3'd4,
    ERR_TRUNC    = 3'd5
  } err_t;

  typedef enum logic [10:0] {
    PH_SIZE  = 11'h001,
    PH_HEX   = 11'h002,
    PH_TAIL  = 11'h004,
    PH_EXT   = 11'h008,
    PH_BAD   = 11'h010,
    PH_DATA  = 11'h020,
    PH_CR    = 11'h040,
    PH_LF    = 11'h080,
    PH_TRAIL = 11'h100,
    PH_DONE  = 11'h200,
    PH_ERR   = 11'h400
  } phase_t;

  // classified body byte
  typedef struct packed {
    logic [7:0] data;
    logic       stream_end;
    logic       is_cr;
    logic       is_lf;
    logic       is_blank;
    logic       is_semi;
    logic       is_hex;
    logic [3:0] hex_val;
  } item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       done;
    err_t       error_code;
  } res_t;

  typedef struct packed {
    logic [1:0]  body_mode;
    logic [63:0] content_length;
    logic [62:0] size_limit;
  } cfg_t;

  typedef struct packed {
    logic in_done;
    logic in_err;
  } sts_t;

endpackage
`default_nettype wire

FILE: rtl/core/hcbd_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hcbd_fifo
// small flop-based queue with registered storage
// ----------------------------------------------------------------------------
module hcbd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_FULL);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/hcbd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hcbd_front
// byte classifier and request queue in front of the decoder
// ----------------------------------------------------------------------------
module hcbd_front #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  output logic                 full,
  input  wire logic [7:0]      in_byte,
  input  wire logic            in_stream_end,
  output logic                 item_valid,
  output hcbd_pkg::item_t      item,
  input  wire logic            item_pop
);

  hcbd_pkg::item_t cls;
  logic            q_empty;
  logic [$bits(hcbd_pkg::item_t)-1:0] q_rdata;

  always_comb begin
    cls            = '0;
    cls.data       = in_byte;
    cls.stream_end = in_stream_end;
    cls.is_cr      = (in_byte == hcbd_pkg::CH_CR);
    cls.is_lf      = (in_byte == hcbd_pkg::CH_LF);
    cls.is_blank   = (in_byte == hcbd_pkg::CH_SPACE) || (in_byte == hcbd_pkg::CH_TAB);
    cls.is_semi    = (in_byte == hcbd_pkg::CH_SEMI);
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      cls.is_hex  = 1'b1;
      cls.hex_val = in_byte[3:0];
    end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                 (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
      // letters a..f / A..F: low nibble 1..6 maps to 10..15
      cls.is_hex  = 1'b1;
      cls.hex_val = in_byte[3:0] + 4'd9;
    end
  end

  hcbd_fifo #(
    .WIDTH ($bits(hcbd_pkg::item_t)),
    .DEPTH (DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (cls),
    .full  (full),
    .pop   (item_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign item_valid = !q_empty;
  assign item       = hcbd_pkg::item_t'(q_rdata);

endmodule
`default_nettype wire

FILE: rtl/core/hcbd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hcbd_back
// decoder state machine, one classified byte per cycle while a byte waits and the result queue has room
// ----------------------------------------------------------------------------
module hcbd_back #(
  parameter int unsigned LINE_LIMIT = 16384
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire hcbd_pkg::cfg_t   cfg,
  input  wire logic             item_valid,
  input  wire hcbd_pkg::item_t  item,
  output logic                  item_pop,
  input  wire logic             res_full,
  output logic                  res_push,
  output hcbd_pkg::res_t        res,
  output hcbd_pkg::sts_t        sts
);

  localparam int unsigned LL_W = $clog2(LINE_LIMIT);
  localparam logic [LL_W-1:0] LL_MAX = LL_W'(LINE_LIMIT - 1);

  hcbd_pkg::phase_t phase_r, phase_nxt;
  logic [63:0]      rem_r, rem_nxt;
  logic [63:0]      acc_r, acc_nxt;
  logic             seen_r, seen_nxt;
  logic [LL_W-1:0]  len_r, len_nxt;
  logic             pcr_r, pcr_nxt;
  logic [63:0]      emitted_r, emitted_nxt;
  hcbd_pkg::err_t   err_r, err_nxt;

  logic        fire;
  logic        finished;
  logic        lim_hit;
  logic        len_full;
  logic [63:0] emitted_inc;

  assign fire        = item_valid && !res_full;
  assign item_pop    = fire;
  assign res_push    = fire;
  assign finished    = (phase_r == hcbd_pkg::PH_DONE) || (phase_r == hcbd_pkg::PH_ERR);
  assign lim_hit     = (emitted_r >= {1'b0, cfg.size_limit});
  assign len_full    = (len_r >= LL_MAX);
  assign emitted_inc = emitted_r + 64'd1;

  always_comb begin
    phase_nxt   = phase_r;
    rem_nxt     = rem_r;
    acc_nxt     = acc_r;
    seen_nxt    = seen_r;
    len_nxt     = len_r;
    pcr_nxt     = pcr_r;
    emitted_nxt = emitted_r;
    err_nxt     = err_r;
    res         = '0;

    if (!finished) begin
      if (cfg.body_mode == hcbd_pkg::MODE_CHUNKED) begin
        if (item.stream_end) begin
          phase_nxt = hcbd_pkg::PH_ERR;
          err_nxt   = (phase_r == hcbd_pkg::PH_CR || phase_r == hcbd_pkg::PH_LF) ?
                      hcbd_pkg::ERR_BAD_TERM : hcbd_pkg::ERR_TRUNC;
        end else begin
          unique case (phase_r)
            hcbd_pkg::PH_DATA: begin
              if (lim_hit) begin
                phase_nxt = hcbd_pkg::PH_ERR;
                err_nxt   = hcbd_pkg::ERR_LIMIT;
              end else begin
                res.data    = item.data;
                res.valid   = 1'b1;
                emitted_nxt = emitted_inc;
                rem_nxt     = rem_r - 64'd1;
                if (rem_r == 64'd1) begin
                  phase_nxt = hcbd_pkg::PH_CR;
                end
              end
            end
            hcbd_pkg::PH_CR: begin
              if (item.is_cr) begin
                phase_nxt = hcbd_pkg::PH_LF;
              end else begin
                phase_nxt = hcbd_pkg::PH_ERR;
                err_nxt   = hcbd_pkg::ERR_BAD_TERM;
              end
            end
            hcbd_pkg::PH_LF: begin
              if (item.is_lf) begin
                len_nxt   = '0;
                pcr_nxt   = 1'b0;
                acc_nxt   = '0;
                seen_nxt  = 1'b0;
                phase_nxt = hcbd_pkg::PH_SIZE;
              end else begin
                phase_nxt = hcbd_pkg::PH_ERR;
                err_nxt   = hcbd_pkg::ERR_BAD_TERM;
              end
            end
            hcbd_pkg::PH_TRAIL: begin
              if (item.is_lf) begin
                // empty line (a lone cr allowed) ends the trailer
                if (len_r == (pcr_r ? LL_W'(1) : LL_W'(0))) begin
                  phase_nxt = hcbd_pkg::PH_DONE;
                end else begin
                  len_nxt = '0;
                  pcr_nxt = 1'b0;
                end
              end else if (len_full) begin
                phase_nxt = hcbd_pkg::PH_ERR;
                err_nxt   = hcbd_pkg::ERR_LONG;
              end else begin
                len_nxt = len_r + LL_W'(1);
                pcr_nxt = item.is_cr;
              end
            end
            default: begin
              // size line states
              if (item.is_lf) begin
                if (phase_r == hcbd_pkg::PH_BAD || !seen_r) begin
                  phase_nxt = hcbd_pkg::PH_ERR;
                  err_nxt   = hcbd_pkg::ERR_BAD_SIZE;
                end else if (acc_r == '0) begin
                  len_nxt   = '0;
                  pcr_nxt   = 1'b0;
                  phase_nxt = hcbd_pkg::PH_TRAIL;
                end else begin
                  rem_nxt   = acc_r;
                  phase_nxt = hcbd_pkg::PH_DATA;
                end
              end else if (len_full) begin
                phase_nxt = hcbd_pkg::PH_ERR;
                err_nxt   = hcbd_pkg::ERR_LONG;
              end else begin
                len_nxt = len_r + LL_W'(1);
                if (phase_r == hcbd_pkg::PH_EXT || phase_r == hcbd_pkg::PH_BAD) begin
                  pcr_nxt = item.is_cr;
                end else if (pcr_r) begin
                  // cr not followed by lf
                  phase_nxt = hcbd_pkg::PH_BAD;
                  pcr_nxt   = item.is_cr;
                end else if (item.is_cr) begin
                  pcr_nxt = 1'b1;
                end else if (item.is_blank) begin
                  if (phase_r == hcbd_pkg::PH_HEX) begin
                    phase_nxt = hcbd_pkg::PH_TAIL;
                  end
                end else if (item.is_semi) begin
                  phase_nxt = hcbd_pkg::PH_EXT;
                end else if (!item.is_hex || phase_r == hcbd_pkg::PH_TAIL ||
                             acc_r[63:60] != 4'd0) begin
                  phase_nxt = hcbd_pkg::PH_BAD;
                end else begin
                  acc_nxt   = {acc_r[59:0], item.hex_val};
                  seen_nxt  = 1'b1;
                  phase_nxt = hcbd_pkg::PH_HEX;
                end
              end
            end
          endcase
        end
      end else if (cfg.body_mode == hcbd_pkg::MODE_FIXED) begin
        if (emitted_r >= cfg.content_length) begin
          phase_nxt = hcbd_pkg::PH_DONE;
        end else if (item.stream_end) begin
          phase_nxt = hcbd_pkg::PH_ERR;
          err_nxt   = hcbd_pkg::ERR_TRUNC;
        end else if (lim_hit) begin
          phase_nxt = hcbd_pkg::PH_ERR;
          err_nxt   = hcbd_pkg::ERR_LIMIT;
        end else begin
          res.data    = item.data;
          res.valid   = 1'b1;
          emitted_nxt = emitted_inc;
          if (emitted_inc == cfg.content_length) begin
            phase_nxt = hcbd_pkg::PH_DONE;
          end
        end
      end else begin
        // read until close
        if (item.stream_end) begin
          phase_nxt = hcbd_pkg::PH_DONE;
        end else if (lim_hit) begin
          phase_nxt = hcbd_pkg::PH_ERR;
          err_nxt   = hcbd_pkg::ERR_LIMIT;
        end else begin
          res.data    = item.data;
          res.valid   = 1'b1;
          emitted_nxt = emitted_inc;
        end
      end
    end

    res.done       = (phase_nxt == hcbd_pkg::PH_DONE);
    res.error_code = (phase_nxt == hcbd_pkg::PH_ERR) ? err_nxt : hcbd_pkg::ERR_NONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= hcbd_pkg::PH_SIZE;
      rem_r     <= '0;
      acc_r     <= '0;
      seen_r    <= 1'b0;
      len_r     <= '0;
      pcr_r     <= 1'b0;
      emitted_r <= '0;
      err_r     <= hcbd_pkg::ERR_NONE;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      rem_r     <= rem_nxt;
      acc_r     <= acc_nxt;
      seen_r    <= seen_nxt;
      len_r     <= len_nxt;
      pcr_r     <= pcr_nxt;
      emitted_r <= emitted_nxt;
      err_r     <= err_nxt;
    end
  end

  assign sts.in_done = (phase_r == hcbd_pkg::PH_DONE);
  assign sts.in_err  = (phase_r == hcbd_pkg::PH_ERR);

endmodule
`default_nettype wire

FILE: rtl/core/http_chunked_body_decoder_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_core
// http/1.1 response body decoder: chunked, fixed length and read-until-close
// ----------------------------------------------------------------------------
// Takes one raw body byte per request and gives exactly one result per
// request: a payload byte with out_valid, or a bare status (done or error
// code). Both sides look like queues: requests go in with push/full, results
// come out with empty/pop. The decoder sustains one byte per clock while a
// request waits and the result queue has room; a request is registered into
// the input queue, then its result through the decoder into the result queue.
// The rate is set by the state update of the decoder stage, which compares a
// 64-bit byte count against the limit. The input queue holds IN_DEPTH
// requests and the result queue OUT_DEPTH results, so either side may stall
// without stopping the other until its queue fills. The user must write
// configuration through cfg_wr_en/cfg_index/cfg_data only while no request is
// in flight; the block does not enforce it. Index 0 is body mode, 1 content
// length, 2 size limit, and other indexes are ignored. After done or an error
// the block reports that status on every later result until reset.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_core #(
  parameter int unsigned LINE_LIMIT = 16384,
  parameter int unsigned IN_DEPTH   = 2,
  parameter int unsigned OUT_DEPTH  = 2
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // request side
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic [7:0]                        in_byte,
  input  wire logic                              in_stream_end,
  // result side
  output logic                                   empty,
  input  wire logic                              pop,
  output logic [7:0]                             out_byte,
  output logic                                   out_valid,
  output logic                                   out_done_res,
  output logic [2:0]                             out_error_code,
  // configuration
  input  wire logic                              cfg_wr_en,
  input  wire logic [hcbd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [hcbd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // configuration registers
  logic [1:0]  body_mode_r;
  logic [63:0] content_length_r;
  logic [62:0] size_limit_r;
  hcbd_pkg::cfg_t cfg;

  // front to back
  logic            item_valid;
  hcbd_pkg::item_t item;
  logic            item_pop;

  // back to result queue
  logic            res_full;
  logic            res_push;
  hcbd_pkg::res_t  res;
  hcbd_pkg::res_t  res_head;
  hcbd_pkg::sts_t  sts;
  logic [$bits(hcbd_pkg::res_t)-1:0] res_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      body_mode_r      <= hcbd_pkg::MODE_CHUNKED;
      content_length_r <= '0;
      size_limit_r     <= hcbd_pkg::SIZE_LIMIT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        hcbd_pkg::CFG_BODY_MODE:      body_mode_r      <= cfg_data[1:0];
        hcbd_pkg::CFG_CONTENT_LENGTH: content_length_r <= cfg_data;
        hcbd_pkg::CFG_SIZE_LIMIT:     size_limit_r     <= cfg_data[62:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  assign cfg.body_mode      = body_mode_r;
  assign cfg.content_length = content_length_r;
  assign cfg.size_limit     = size_limit_r;

  // classify incoming bytes and queue them
  hcbd_front #(
    .DEPTH (IN_DEPTH)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_byte       (in_byte),
    .in_stream_end (in_stream_end),
    .item_valid    (item_valid),
    .item          (item),
    .item_pop      (item_pop)
  );

  // decoder state machine
  hcbd_back #(
    .LINE_LIMIT (LINE_LIMIT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res),
    .sts        (sts)
  );

  // result queue decouples the decoder from the consumer
  hcbd_fifo #(
    .WIDTH ($bits(hcbd_pkg::res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign res_head       = hcbd_pkg::res_t'(res_rdata);
  assign out_byte       = res_head.data;
  assign out_valid      = res_head.valid;
  assign out_done_res   = res_head.done;
  assign out_error_code = res_head.error_code;

  // a payload byte is never reported together with an error
  a_valid_no_error: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_valid) |-> (out_error_code == hcbd_pkg::ERR_NONE))
    else $error("payload result carries an error code");

  // error state is terminal until reset
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    sts.in_err |=> sts.in_err)
    else $error("decoder left error state");

  // done state is terminal until reset
  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    sts.in_done |=> sts.in_done)
    else $error("decoder left done state");

endmodule
`default_nettype wire
